### sv/mpa_pkg.sv
// ----------------------------------------------------------------------------
// mpa_pkg
// Shared types and fixed constants of the 2-D max pooling with argmax block.
// ----------------------------------------------------------------------------
package mpa_pkg;

   // Configuration register widths
   localparam int CSR_DATA_W    = 11;
   localparam int CSR_INDEX_W   = 2;
   localparam int WIN_W         = 4;
   localparam int ROWS_REG_W    = 11;
   localparam int COLS_REG_W    = 11;
   localparam int CHAN_REG_W    = 9;

   // Register reset values
   localparam logic [WIN_W-1:0]      WIN_RESET  = 4'd2;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 11'd28;
   localparam logic [COLS_REG_W-1:0] COLS_RESET = 11'd28;
   localparam logic [CHAN_REG_W-1:0] CHAN_RESET = 9'd1;

   // Upper limits of the row and channel registers
   localparam logic [ROWS_REG_W-1:0] ROWS_LIMIT = 11'd1024;
   localparam logic [CHAN_REG_W-1:0] CHAN_LIMIT = 9'd256;

   // Position and result field widths
   localparam int ROW_POS_W = 10;
   localparam int CH_POS_W  = 8;
   localparam int OFF_W     = 3;
   localparam int IDX_W     = 10;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_SIZE   = 2'd0,
      CSR_MAP_ROWS      = 2'd1,
      CSR_MAP_COLS      = 2'd2,
      CSR_CHANNEL_COUNT = 2'd3
   } csr_index_type;

   // Window decomposition sequencer
   typedef enum logic [2:0] {
      DIV_IDLE = 3'b001,
      DIV_LOAD = 3'b010,
      DIV_RUN  = 3'b100
   } seq_state_type;

   // Result fields other than the value
   typedef struct packed {
      logic [OFF_W-1:0]    row_off;
      logic [OFF_W-1:0]    col_off;
      logic [IDX_W-1:0]    row;
      logic [IDX_W-1:0]    col;
      logic [CH_POS_W-1:0] channel;
      logic                frame_end;
   } rsp_info_type;

endpackage

### sv/max_pool_argmax_2d.sv
// ----------------------------------------------------------------------------
// max_pool_argmax_2d
// A window's result passes the update stage and then the result queue before it is valid.
// Throughput: one sample per cycle while intake is not stalled, set by the read-modify-write of the column store.
// After reset and after every register write, intake stalls while the window
// decomposition is recomputed serially; it also stalls while the result queue is full.
// Reset is synchronous, active high; the column store holds no defined contents.
// ----------------------------------------------------------------------------
module max_pool_argmax_2d #(
   parameter int MAX_COLS     = 1024,
   parameter int MAX_WINDOW   = 8,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // sample channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_max_value,
   output logic [mpa_pkg::OFF_W-1:0]            rsp_best_row_offset,
   output logic [mpa_pkg::OFF_W-1:0]            rsp_best_col_offset,
   output logic [mpa_pkg::IDX_W-1:0]            rsp_out_row,
   output logic [mpa_pkg::IDX_W-1:0]            rsp_out_col,
   output logic [mpa_pkg::CH_POS_W-1:0]         rsp_out_channel,
   output logic                                 rsp_frame_end,
   // configuration
   input  logic                                 csr_write,
   input  logic [mpa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mpa_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int AW    = $clog2(MAX_COLS);
   localparam int DW    = (AW > mpa_pkg::COLS_REG_W) ? AW : mpa_pkg::COLS_REG_W;
   localparam int XW    = DW + 1;
   localparam int CNTW  = $clog2(DW);
   localparam int WW    = mpa_pkg::WIN_W;
   localparam int RW    = mpa_pkg::ROW_POS_W;
   localparam int HW    = mpa_pkg::CH_POS_W;
   localparam int OW    = mpa_pkg::OFF_W;
   localparam int RRW   = mpa_pkg::ROWS_REG_W;
   localparam int CRW   = mpa_pkg::COLS_REG_W;
   localparam int NRW   = mpa_pkg::CHAN_REG_W;
   localparam int PW    = mpa_pkg::FIFO_PTR_W;
   localparam int LANES = 4;
   localparam int LANE_ROW   = 0;
   localparam int LANE_COL   = 1;
   localparam int LANE_ROWS  = 2;
   localparam int LANE_COLS  = 3;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [WW-1:0]  window_size_ff;
   logic [RRW-1:0] map_rows_ff;
   logic [CRW-1:0] map_cols_ff;
   logic [NRW-1:0] channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff   <= mpa_pkg::WIN_RESET;
         map_rows_ff      <= mpa_pkg::ROWS_RESET;
         map_cols_ff      <= mpa_pkg::COLS_RESET;
         channel_count_ff <= mpa_pkg::CHAN_RESET;
      end else if (csr_write) begin
         case (mpa_pkg::csr_index_type'(csr_index))
            mpa_pkg::CSR_WINDOW_SIZE:   window_size_ff   <= csr_wdata[WW-1:0];
            mpa_pkg::CSR_MAP_ROWS:      map_rows_ff      <= csr_wdata[RRW-1:0];
            mpa_pkg::CSR_MAP_COLS:      map_cols_ff      <= csr_wdata[CRW-1:0];
            mpa_pkg::CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[NRW-1:0];
            default: ;
         endcase
      end
   end

   // Effective sizes: zero acts as one, large values saturate
   logic [WW-1:0]  w_eff;
   logic [RRW-1:0] rows_eff;
   logic [CRW-1:0] cols_eff;
   logic [NRW-1:0] chans_eff;

   always_comb begin
      if (window_size_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(window_size_ff) > MAX_WINDOW) begin
         w_eff = WW'(MAX_WINDOW);
      end else begin
         w_eff = window_size_ff;
      end

      if (map_rows_ff == '0) begin
         rows_eff = RRW'(1);
      end else if (map_rows_ff > mpa_pkg::ROWS_LIMIT) begin
         rows_eff = mpa_pkg::ROWS_LIMIT;
      end else begin
         rows_eff = map_rows_ff;
      end

      if (map_cols_ff == '0) begin
         cols_eff = CRW'(1);
      end else if (32'(map_cols_ff) > MAX_COLS) begin
         cols_eff = CRW'(MAX_COLS);
      end else begin
         cols_eff = map_cols_ff;
      end

      if (channel_count_ff == '0) begin
         chans_eff = NRW'(1);
      end else if (channel_count_ff > mpa_pkg::CHAN_LIMIT) begin
         chans_eff = mpa_pkg::CHAN_LIMIT;
      end else begin
         chans_eff = channel_count_ff;
      end
   end

   // ------------------------------------------------------------------
   // Position state
   // ------------------------------------------------------------------
   logic [RW-1:0]  row_pos_ff, row_pos_in;
   logic [AW-1:0]  col_pos_ff, col_pos_in;
   logic [HW-1:0]  ch_pos_ff,  ch_pos_in;
   logic [RW-1:0]  pool_row_ff, pool_row_in;   // row / w
   logic [WW-1:0]  win_row_ff,  win_row_in;    // row % w
   logic [AW-1:0]  pool_col_ff, pool_col_in;   // col / w
   logic [WW-1:0]  win_col_ff,  win_col_in;    // col % w
   logic [RRW-1:0] pool_rows_ff, pool_rows_in; // rows / w
   logic [CRW-1:0] pool_cols_ff, pool_cols_in; // cols / w

   // ------------------------------------------------------------------
   // Serial divider: four restoring lanes share one sequencer
   // ------------------------------------------------------------------
   mpa_pkg::seq_state_type seq_state_ff, seq_state_in;
   logic [CNTW-1:0] step_cnt_ff, step_cnt_in;
   logic [DW-1:0]   lane_q_ff   [LANES];
   logic [WW:0]     lane_rem_ff [LANES];
   logic [DW-1:0]   lane_q_step   [LANES];
   logic [WW:0]     lane_rem_step [LANES];
   logic            div_done;
   logic            busy;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [WW:0] trial;
      logic        fits;
      assign trial = {lane_rem_ff[g][WW-1:0], lane_q_ff[g][DW-1]};
      assign fits  = trial >= {1'b0, w_eff};
      assign lane_rem_step[g] = fits ? (trial - {1'b0, w_eff}) : trial;
      assign lane_q_step[g]   = {lane_q_ff[g][DW-2:0], fits};
   end

   assign busy     = (seq_state_ff != mpa_pkg::DIV_IDLE);
   assign div_done = (seq_state_ff == mpa_pkg::DIV_RUN) && (step_cnt_ff == CNTW'(DW - 1));

   // Any register write restarts the decomposition
   always_comb begin
      seq_state_in = seq_state_ff;
      step_cnt_in  = step_cnt_ff;
      case (seq_state_ff)
         mpa_pkg::DIV_IDLE: ;
         mpa_pkg::DIV_LOAD: begin
            seq_state_in = mpa_pkg::DIV_RUN;
            step_cnt_in  = '0;
         end
         mpa_pkg::DIV_RUN: begin
            step_cnt_in = step_cnt_ff + CNTW'(1);
            if (div_done) begin
               seq_state_in = mpa_pkg::DIV_IDLE;
            end
         end
         default: seq_state_in = mpa_pkg::DIV_LOAD;
      endcase
      if (csr_write) begin
         seq_state_in = mpa_pkg::DIV_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_state_ff <= mpa_pkg::DIV_LOAD;
         step_cnt_ff  <= '0;
      end else begin
         seq_state_ff <= seq_state_in;
         step_cnt_ff  <= step_cnt_in;
      end
   end

   // Lane datapath
   always_ff @(posedge clock) begin
      if (seq_state_ff == mpa_pkg::DIV_LOAD) begin
         lane_q_ff[LANE_ROW]  <= DW'(row_pos_ff);
         lane_q_ff[LANE_COL]  <= DW'(col_pos_ff);
         lane_q_ff[LANE_ROWS] <= DW'(rows_eff);
         lane_q_ff[LANE_COLS] <= DW'(cols_eff);
         for (int i = 0; i < LANES; i++) begin
            lane_rem_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < LANES; i++) begin
            lane_q_ff[i]   <= lane_q_step[i];
            lane_rem_ff[i] <= lane_rem_step[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Sample intake and position stepping
   // ------------------------------------------------------------------
   localparam int FCW = PW + 1;

   logic [FCW-1:0] fifo_count_ff, fifo_count_in;
   logic           push;
   logic           pop;
   logic           req_accept;
   logic           in_window;
   logic           win_first;
   logic           win_end;
   logic           frame_last;
   logic           col_wrap;
   logic           row_wrap;
   logic           ch_wrap;

   assign req_stall  = busy || ((FCW'(fifo_count_ff) + FCW'(push)) >=
                                FCW'(mpa_pkg::FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;

   assign col_wrap  = (XW'(col_pos_ff) + XW'(1)) >= XW'(cols_eff);
   assign row_wrap  = ({1'b0, row_pos_ff} + RRW'(1)) >= rows_eff;
   assign ch_wrap   = ({1'b0, ch_pos_ff} + NRW'(1)) >= chans_eff;
   assign in_window = ({1'b0, pool_row_ff} < pool_rows_ff) &&
                      (XW'(pool_col_ff) < XW'(pool_cols_ff));
   assign win_first = (win_row_ff == '0) && (win_col_ff == '0);
   assign win_end   = (win_row_ff == w_eff - WW'(1)) && (win_col_ff == w_eff - WW'(1));
   assign frame_last = ch_wrap && (({1'b0, pool_row_ff} + RRW'(1)) >= pool_rows_ff) &&
                       ((XW'(pool_col_ff) + XW'(1)) >= XW'(pool_cols_ff));

   always_comb begin
      row_pos_in   = row_pos_ff;
      col_pos_in   = col_pos_ff;
      ch_pos_in    = ch_pos_ff;
      pool_row_in  = pool_row_ff;
      win_row_in   = win_row_ff;
      pool_col_in  = pool_col_ff;
      win_col_in   = win_col_ff;
      pool_rows_in = pool_rows_ff;
      pool_cols_in = pool_cols_ff;

      // load quotients and remainders from the divider
      if (div_done) begin
         pool_row_in  = lane_q_step[LANE_ROW][RW-1:0];
         win_row_in   = lane_rem_step[LANE_ROW][WW-1:0];
         pool_col_in  = lane_q_step[LANE_COL][AW-1:0];
         win_col_in   = lane_rem_step[LANE_COL][WW-1:0];
         pool_rows_in = lane_q_step[LANE_ROWS][RRW-1:0];
         pool_cols_in = lane_q_step[LANE_COLS][CRW-1:0];
      end

      // raster step on every transfer
      if (req_accept) begin
         if (col_wrap) begin
            col_pos_in  = '0;
            pool_col_in = '0;
            win_col_in  = '0;
            if (row_wrap) begin
               row_pos_in  = '0;
               pool_row_in = '0;
               win_row_in  = '0;
               ch_pos_in   = ch_wrap ? '0 : ch_pos_ff + HW'(1);
            end else begin
               row_pos_in = row_pos_ff + RW'(1);
               if (win_row_ff + WW'(1) == w_eff) begin
                  win_row_in  = '0;
                  pool_row_in = pool_row_ff + RW'(1);
               end else begin
                  win_row_in = win_row_ff + WW'(1);
               end
            end
         end else begin
            col_pos_in = col_pos_ff + AW'(1);
            if (win_col_ff + WW'(1) == w_eff) begin
               win_col_in  = '0;
               pool_col_in = pool_col_ff + AW'(1);
            end else begin
               win_col_in = win_col_ff + WW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff   <= '0;
         col_pos_ff   <= '0;
         ch_pos_ff    <= '0;
         pool_row_ff  <= '0;
         win_row_ff   <= '0;
         pool_col_ff  <= '0;
         win_col_ff   <= '0;
         pool_rows_ff <= '0;
         pool_cols_ff <= '0;
      end else begin
         row_pos_ff   <= row_pos_in;
         col_pos_ff   <= col_pos_in;
         ch_pos_ff    <= ch_pos_in;
         pool_row_ff  <= pool_row_in;
         win_row_ff   <= win_row_in;
         pool_col_ff  <= pool_col_in;
         win_col_ff   <= win_col_in;
         pool_rows_ff <= pool_rows_in;
         pool_cols_ff <= pool_cols_in;
      end
   end

   // ------------------------------------------------------------------
   // Column store: running max and its offset per pooled column
   // ------------------------------------------------------------------
   logic signed [SAMPLE_WIDTH-1:0] partial_max_mem [MAX_COLS];
   logic [2*OW-1:0]                partial_off_mem [MAX_COLS];
   logic signed [SAMPLE_WIDTH-1:0] rd_max_ff;
   logic [2*OW-1:0]                rd_off_ff;

   // update stage
   logic                           upd_valid_ff;
   logic                           upd_first_ff;
   logic                           upd_end_ff;
   logic signed [SAMPLE_WIDTH-1:0] upd_sample_ff;
   logic [AW-1:0]                  upd_addr_ff;
   logic [2*OW-1:0]                upd_off_ff;
   mpa_pkg::rsp_info_type          upd_info_ff;

   // last write, forwarded to a read issued on the same edge
   logic                           lw_valid_ff;
   logic [AW-1:0]                  lw_addr_ff;
   logic signed [SAMPLE_WIDTH-1:0] lw_max_ff;
   logic [2*OW-1:0]                lw_off_ff;

   logic                           use_fwd;
   logic signed [SAMPLE_WIDTH-1:0] cur_max;
   logic [2*OW-1:0]                cur_off;
   logic                           take_new;
   logic signed [SAMPLE_WIDTH-1:0] new_max;
   logic [2*OW-1:0]                new_off;

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_valid_ff <= 1'b0;
      end else begin
         upd_valid_ff <= req_accept && in_window;
      end
   end

   // stage registers and store read
   always_ff @(posedge clock) begin
      if (req_accept && in_window) begin
         rd_max_ff     <= partial_max_mem[pool_col_ff];
         rd_off_ff     <= partial_off_mem[pool_col_ff];
         upd_first_ff  <= win_first;
         upd_end_ff    <= win_end;
         upd_sample_ff <= req_sample;
         upd_addr_ff   <= pool_col_ff;
         upd_off_ff    <= {win_row_ff[OW-1:0], win_col_ff[OW-1:0]};
         upd_info_ff.row_off   <= '0;
         upd_info_ff.col_off   <= '0;
         upd_info_ff.row       <= mpa_pkg::IDX_W'(pool_row_ff);
         upd_info_ff.col       <= mpa_pkg::IDX_W'(pool_col_ff);
         upd_info_ff.channel   <= ch_pos_ff;
         upd_info_ff.frame_end <= frame_last;
      end
   end

   // compare against the kept max; the first sample of a window or a strictly greater one replaces
   assign use_fwd  = lw_valid_ff && (lw_addr_ff == upd_addr_ff);
   assign cur_max  = use_fwd ? lw_max_ff : rd_max_ff;
   assign cur_off  = use_fwd ? lw_off_ff : rd_off_ff;
   assign take_new = upd_first_ff || (upd_sample_ff > cur_max);
   assign new_max  = take_new ? upd_sample_ff : cur_max;
   assign new_off  = take_new ? upd_off_ff : cur_off;

   // write back
   always_ff @(posedge clock) begin
      if (upd_valid_ff) begin
         partial_max_mem[upd_addr_ff] <= new_max;
         partial_off_mem[upd_addr_ff] <= new_off;
         lw_addr_ff <= upd_addr_ff;
         lw_max_ff  <= new_max;
         lw_off_ff  <= new_off;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_valid_ff <= 1'b0;
      end else if (upd_valid_ff) begin
         lw_valid_ff <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   logic signed [SAMPLE_WIDTH-1:0] fifo_max  [mpa_pkg::FIFO_DEPTH];
   mpa_pkg::rsp_info_type          fifo_info [mpa_pkg::FIFO_DEPTH];
   logic [PW-1:0]                  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]                  rd_ptr_ff, rd_ptr_in;
   mpa_pkg::rsp_info_type          push_info;
   mpa_pkg::rsp_info_type          head_info;

   assign push = upd_valid_ff && upd_end_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      push_info         = upd_info_ff;
      push_info.row_off = new_off[2*OW-1:OW];
      push_info.col_off = new_off[OW-1:0];
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_max[wr_ptr_ff]  <= new_max;
         fifo_info[wr_ptr_ff] <= push_info;
      end
   end

   always_comb begin
      wr_ptr_in     = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in     = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      fifo_count_in = fifo_count_ff + FCW'(push) - FCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fifo_count_ff <= fifo_count_in;
      end
   end

   assign head_info           = fifo_info[rd_ptr_ff];
   assign rsp_valid           = (fifo_count_ff != '0);
   assign rsp_max_value       = fifo_max[rd_ptr_ff];
   assign rsp_best_row_offset = head_info.row_off;
   assign rsp_best_col_offset = head_info.col_off;
   assign rsp_out_row         = head_info.row;
   assign rsp_out_col         = head_info.col;
   assign rsp_out_channel     = head_info.channel;
   assign rsp_frame_end       = head_info.frame_end;

endmodule

### sv/mpa_checker.sv
// ----------------------------------------------------------------------------
// mpa_checker
// Port-level checks for max_pool_argmax_2d, bound to the top level.
// ----------------------------------------------------------------------------
module mpa_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_max_value,
   input logic                           csr_write
);

   // Intake is held off while the window decomposition runs after reset
   a_reset_stalls: assert property (@(posedge clock) reset |=> req_stall)
      else $error("sample transfer possible right after reset");

   // A register write restarts the decomposition and closes intake
   a_csr_stalls: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> req_stall)
      else $error("sample transfer possible right after register write");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_max_value))
      else $error("stalled result changed");

   // A result that appears from an empty queue traces back to a sample transfer through the update stage
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without matching sample transfer");

endmodule

bind max_pool_argmax_2d mpa_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_mpa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_max_value (rsp_max_value),
   .csr_write     (csr_write)
);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming 2-D max pooling with argmax block.
// A short directed list covers sample extremes, ties, leftover rows and
// columns and register values that clamp. A clamped window size follows,
// then random pooling phases that change the registers at frame or band
// boundaries. Every result is checked field by field against an in-bench
// pooling model, under several sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_WIN      = 8;
   localparam int MAX_COL      = 1024;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEM_COUNT   = 400;
   localparam int DATA_W       = mpa_pkg::CSR_DATA_W;

   // One pooled window as the block reports it
   typedef struct packed {
      logic signed [15:0]    max_value;
      mpa_pkg::rsp_info_type info;
   } pool_result_type;

   // One line of the directed list: a register write or a sample
   typedef struct {
      bit                             is_write;
      mpa_pkg::csr_index_type         reg_idx;
      logic [mpa_pkg::CSR_DATA_W-1:0] reg_val;
      logic signed [15:0]             smp;
      bit                             has_exp;
      pool_result_type                exp;
   } stim_row_type;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_valid  = 1'b0;
   logic                               req_stall;
   logic signed [15:0]                 req_sample = '0;
   logic                               rsp_valid;
   logic                               rsp_stall  = 1'b0;
   logic signed [15:0]                 rsp_max_value;
   logic [mpa_pkg::OFF_W-1:0]          rsp_best_row_offset;
   logic [mpa_pkg::OFF_W-1:0]          rsp_best_col_offset;
   logic [mpa_pkg::IDX_W-1:0]          rsp_out_row;
   logic [mpa_pkg::IDX_W-1:0]          rsp_out_col;
   logic [mpa_pkg::CH_POS_W-1:0]       rsp_out_channel;
   logic                               rsp_frame_end;
   logic                               csr_write  = 1'b0;
   logic [mpa_pkg::CSR_INDEX_W-1:0]    csr_index  = '0;
   logic [mpa_pkg::CSR_DATA_W-1:0]     csr_wdata  = '0;

   // Pooling model state: raw registers, raster position, column band store
   int unsigned               win_reg  = 2;
   int unsigned               rows_reg = 28;
   int unsigned               cols_reg = 28;
   int unsigned               chan_reg = 1;
   int unsigned               col_pos  = 0;
   int unsigned               row_pos  = 0;
   int unsigned               ch_pos   = 0;
   logic signed [15:0]        band_max [MAX_COL];
   logic [mpa_pkg::OFF_W-1:0] band_ri  [MAX_COL];
   logic [mpa_pkg::OFF_W-1:0] band_cj  [MAX_COL];

   pool_result_type window_results_q[$];
   stim_row_type    directed_rows[$];
   int              mismatch_count = 0;
   int              send_idle_pct  = 0;
   int              stall_pct      = 0;
   int              phase_count    = 0;
   int              items_sent     = 0;

   always #4 clock = ~clock;

   max_pool_argmax_2d dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_max_value       (rsp_max_value),
      .rsp_best_row_offset (rsp_best_row_offset),
      .rsp_best_col_offset (rsp_best_col_offset),
      .rsp_out_row         (rsp_out_row),
      .rsp_out_col         (rsp_out_col),
      .rsp_out_channel     (rsp_out_channel),
      .rsp_frame_end       (rsp_frame_end),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Register value as the block uses it: zero acts as one, top is clamped
   function automatic int unsigned reg_eff(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Pool one sample; returns 1 when it closes a window
   function automatic bit pool_sample(input logic signed [15:0] s,
                                      output pool_result_type res);
      int unsigned w, nrows, ncols, nch, pr, ri, pc, cj;
      bit          done;
      w     = reg_eff(win_reg, MAX_WIN);
      nrows = reg_eff(rows_reg, 32'(mpa_pkg::ROWS_LIMIT));
      ncols = reg_eff(cols_reg, MAX_COL);
      nch   = reg_eff(chan_reg, 32'(mpa_pkg::CHAN_LIMIT));
      pr    = row_pos / w;
      ri    = row_pos % w;
      pc    = col_pos / w;
      cj    = col_pos % w;
      done  = 1'b0;
      res   = '0;
      if (pr < nrows / w && pc < ncols / w) begin
         // first sample of a window always loads; later ones only if strictly greater
         if ((ri == 0 && cj == 0) || s > band_max[pc]) begin
            band_max[pc] = s;
            band_ri[pc]  = ri[mpa_pkg::OFF_W-1:0];
            band_cj[pc]  = cj[mpa_pkg::OFF_W-1:0];
         end
         if (ri == w - 1 && cj == w - 1) begin
            done                = 1'b1;
            res.max_value       = band_max[pc];
            res.info.row_off    = band_ri[pc];
            res.info.col_off    = band_cj[pc];
            res.info.row        = pr[mpa_pkg::IDX_W-1:0];
            res.info.col        = pc[mpa_pkg::IDX_W-1:0];
            res.info.channel    = ch_pos[mpa_pkg::CH_POS_W-1:0];
            res.info.frame_end  = (ch_pos + 1 >= nch) && (pr + 1 >= nrows / w) &&
                                  (pc + 1 >= ncols / w);
         end
      end
      // raster advance with wrap at plane and frame ends
      if (col_pos + 1 >= ncols) begin
         col_pos = 0;
         if (row_pos + 1 >= nrows) begin
            row_pos = 0;
            ch_pos  = (ch_pos + 1 >= nch) ? 0 : ch_pos + 1;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = col_pos + 1;
      end
      return done;
   endfunction

   function automatic logic signed [15:0] rand_sample();
      logic signed [15:0] t;
      case ($urandom_range(3))
         0: t = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         1: begin
            // narrow range so ties are frequent
            t = signed'(16'($urandom_range(4))) - 16'sd2;
         end
         default: t = 16'($urandom);
      endcase
      return t;
   endfunction

   // Present one sample until its transfer
   task automatic send_sample(input logic signed [15:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Send a sample, advance the model and queue what it should produce
   task automatic apply_sample(input logic signed [15:0] s, input bit typed,
                               input pool_result_type typed_res);
      pool_result_type res;
      bit              hit;
      send_sample(s);
      items_sent++;
      hit = pool_sample(s, res);
      if (typed) window_results_q.push_back(typed_res);
      else if (hit) window_results_q.push_back(res);
   endtask

   // Stop sending and let every queued window come out
   task automatic drain_results();
      req_valid <= 1'b0;
      while (window_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input mpa_pkg::csr_index_type idx,
                            input logic [mpa_pkg::CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         mpa_pkg::CSR_WINDOW_SIZE:   win_reg  = 32'(v[mpa_pkg::WIN_W-1:0]);
         mpa_pkg::CSR_MAP_ROWS:      rows_reg = 32'(v[mpa_pkg::ROWS_REG_W-1:0]);
         mpa_pkg::CSR_MAP_COLS:      cols_reg = 32'(v[mpa_pkg::COLS_REG_W-1:0]);
         mpa_pkg::CSR_CHANNEL_COUNT: chan_reg = 32'(v[mpa_pkg::CHAN_REG_W-1:0]);
         default: ;
      endcase
   endtask

   // Empty line of the directed list
   function automatic stim_row_type blank_row();
      stim_row_type row;
      row.is_write = 1'b0;
      row.reg_idx  = mpa_pkg::CSR_WINDOW_SIZE;
      row.reg_val  = '0;
      row.smp      = '0;
      row.has_exp  = 1'b0;
      row.exp      = '0;
      return row;
   endfunction

   task automatic add_write(input mpa_pkg::csr_index_type idx,
                            input logic [mpa_pkg::CSR_DATA_W-1:0] v);
      stim_row_type row;
      row          = blank_row();
      row.is_write = 1'b1;
      row.reg_idx  = idx;
      row.reg_val  = v;
      directed_rows.push_back(row);
   endtask

   task automatic add_sample(input logic signed [15:0] s);
      stim_row_type row;
      row     = blank_row();
      row.smp = s;
      directed_rows.push_back(row);
   endtask

   task automatic add_sample_expect(input logic signed [15:0] s, input logic signed [15:0] v,
                                    input logic [mpa_pkg::OFF_W-1:0] ro,
                                    input logic [mpa_pkg::OFF_W-1:0] co,
                                    input logic [mpa_pkg::IDX_W-1:0] r,
                                    input logic [mpa_pkg::IDX_W-1:0] c,
                                    input logic [mpa_pkg::CH_POS_W-1:0] ch, input bit fe);
      stim_row_type row;
      row                    = blank_row();
      row.smp                = s;
      row.has_exp            = 1'b1;
      row.exp.max_value      = v;
      row.exp.info.row_off   = ro;
      row.exp.info.col_off   = co;
      row.exp.info.row       = r;
      row.exp.info.col       = c;
      row.exp.info.channel   = ch;
      row.exp.info.frame_end = fe;
      directed_rows.push_back(row);
   endtask

   // One pooling phase: wait for idle, program, stream random samples
   // until the target is met at a band boundary
   task automatic run_phase(input logic [mpa_pkg::CSR_DATA_W-1:0] w,
                            input logic [mpa_pkg::CSR_DATA_W-1:0] r,
                            input logic [mpa_pkg::CSR_DATA_W-1:0] c,
                            input logic [mpa_pkg::CSR_DATA_W-1:0] ch,
                            input int target);
      int sent;
      drain_results();
      case (phase_count % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 77; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 77; end
         default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      phase_count++;
      write_reg(mpa_pkg::CSR_WINDOW_SIZE, w);
      write_reg(mpa_pkg::CSR_MAP_ROWS, r);
      write_reg(mpa_pkg::CSR_MAP_COLS, c);
      write_reg(mpa_pkg::CSR_CHANNEL_COUNT, ch);
      sent = 0;
      do begin
         apply_sample(rand_sample(), 1'b0, '0);
         sent++;
      end while (!(sent >= target && col_pos == 0 &&
                   row_pos % reg_eff(win_reg, MAX_WIN) == 0));
   endtask

   // Result checker and receiver stall generator
   always @(posedge clock) begin : check_results
      pool_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (window_results_q.size() == 0) begin
            $error("result with nothing expected: max_value %0d row %0d col %0d",
                   rsp_max_value, rsp_out_row, rsp_out_col);
            mismatch_count++;
         end else begin
            want = window_results_q.pop_front();
            if (rsp_max_value !== want.max_value) begin
               $error("max_value: expected %0d, got %0d", want.max_value, rsp_max_value);
               mismatch_count++;
            end
            if (rsp_best_row_offset !== want.info.row_off) begin
               $error("best_row_offset: expected %0d, got %0d", want.info.row_off,
                      rsp_best_row_offset);
               mismatch_count++;
            end
            if (rsp_best_col_offset !== want.info.col_off) begin
               $error("best_col_offset: expected %0d, got %0d", want.info.col_off,
                      rsp_best_col_offset);
               mismatch_count++;
            end
            if (rsp_out_row !== want.info.row) begin
               $error("out_row: expected %0d, got %0d", want.info.row, rsp_out_row);
               mismatch_count++;
            end
            if (rsp_out_col !== want.info.col) begin
               $error("out_col: expected %0d, got %0d", want.info.col, rsp_out_col);
               mismatch_count++;
            end
            if (rsp_out_channel !== want.info.channel) begin
               $error("out_channel: expected %0d, got %0d", want.info.channel,
                      rsp_out_channel);
               mismatch_count++;
            end
            if (rsp_frame_end !== want.info.frame_end) begin
               $error("frame_end: expected %0d, got %0d", want.info.frame_end,
                      rsp_frame_end);
               mismatch_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Main sequence
   initial begin
      int unsigned wr, we, rr, cr, chr;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // 2x2 windows, two planes: sample extremes, then a tie won by the first
      add_write(mpa_pkg::CSR_WINDOW_SIZE, 11'd2);
      add_write(mpa_pkg::CSR_MAP_ROWS, 11'd2);
      add_write(mpa_pkg::CSR_MAP_COLS, 11'd2);
      add_write(mpa_pkg::CSR_CHANNEL_COUNT, 11'd2);
      add_sample(16'sh8000);
      add_sample(16'sh8000);
      add_sample(16'sh8000);
      add_sample_expect(16'sh7FFF, 16'sh7FFF, 3'd1, 3'd1, 10'd0, 10'd0, 8'd0, 1'b0);
      add_sample(16'sd5);
      add_sample(16'sd5);
      add_sample(16'sd5);
      add_sample_expect(16'sd5, 16'sd5, 3'd0, 3'd0, 10'd0, 10'd0, 8'd1, 1'b1);
      // 3x3 plane with 2x2 windows: leftover row and column are dropped,
      // channel count of zero acts as one
      add_write(mpa_pkg::CSR_WINDOW_SIZE, 11'd2);
      add_write(mpa_pkg::CSR_MAP_ROWS, 11'd3);
      add_write(mpa_pkg::CSR_MAP_COLS, 11'd3);
      add_write(mpa_pkg::CSR_CHANNEL_COUNT, 11'd0);
      add_sample(16'sd1);
      add_sample(16'sd2);
      add_sample(16'sd100);
      add_sample(16'sd3);
      add_sample_expect(-16'sd1, 16'sd3, 3'd1, 3'd0, 10'd0, 10'd0, 8'd0, 1'b1);
      add_sample(16'sd100);
      add_sample(16'sd100);
      add_sample(16'sd100);
      add_sample(16'sd100);
      // single-sample windows on a 1x1 plane
      add_write(mpa_pkg::CSR_WINDOW_SIZE, 11'd1);
      add_write(mpa_pkg::CSR_MAP_ROWS, 11'd1);
      add_write(mpa_pkg::CSR_MAP_COLS, 11'd1);
      add_write(mpa_pkg::CSR_CHANNEL_COUNT, 11'd1);
      add_sample_expect(16'sd0, 16'sd0, 3'd0, 3'd0, 10'd0, 10'd0, 8'd0, 1'b1);
      add_sample_expect(-16'sd1, -16'sd1, 3'd0, 3'd0, 10'd0, 10'd0, 8'd0, 1'b1);

      send_idle_pct = 11;
      stall_pct     = 11;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            drain_results();
            write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         end else begin
            apply_sample(directed_rows[i].smp, directed_rows[i].has_exp,
                         directed_rows[i].exp);
         end
      end

      // Window size above the limit clamps: one 8x8 window
      run_phase(11'd15, 11'd8, 11'd8, 11'd1, 64);

      // Random phases; a window change is only taken at a band boundary
      while (items_sent < ITEM_COUNT) begin
         wr = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8, 0);
         if (row_pos % reg_eff(wr, MAX_WIN) != 0) wr = win_reg;
         we  = reg_eff(wr, MAX_WIN);
         rr  = $urandom_range(2 * we + 2, 0);
         cr  = $urandom_range(2 * we + 2, 0);
         chr = $urandom_range(3, 0);
         run_phase(DATA_W'(wr), DATA_W'(rr), DATA_W'(cr), DATA_W'(chr),
                   $urandom_range(60, 10));
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("max_pool_argmax_2d: match");
      end else begin
         $display("max_pool_argmax_2d: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("max_pool_argmax_2d: mismatch");
      $finish;
   end

endmodule

### files.f
sv/mpa_pkg.sv
sv/max_pool_argmax_2d.sv
sv/mpa_checker.sv
verif/tb.sv
